/* rtl/core/html_entity_decoder_defines.svh */
// Assertion macros used by the port-level checker of the entity decoder.
`ifndef HTML_ENTITY_DECODER_DEFINES_SVH
`define HTML_ENTITY_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define HED_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("entity decoder check failed");

// Next-cycle implication, disabled while reset is low.
`define HED_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("entity decoder check failed");

`endif

/* rtl/core/hed_pkg.sv */
// Package of the entity decoder: character codes, name table and UTF-8 helpers.
package hed_pkg;

    localparam int MAX_ENTITY_LEN_DEF = 32;
    localparam int NAME_COUNT         = 240;

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_X_LO = 8'h78;
    localparam logic [7:0] CH_X_UP = 8'h58;

    localparam logic [20:0] CP_MAX = 21'h10FFFF;

    // parse progress of an open reference
    localparam logic [2:0] K_AMP  = 3'd0;
    localparam logic [2:0] K_HASH = 3'd1;
    localparam logic [2:0] K_DEC  = 3'd2;
    localparam logic [2:0] K_HEX  = 3'd3;
    localparam logic [2:0] K_NAME = 3'd4;

    typedef struct packed {
        logic [63:0] nm;   // name, last char in the low byte
        logic [15:0] cp;
    } ent_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] d;
    } digit_t;

    function automatic ent_t ent(input logic [63:0] nm, input logic [15:0] cp);
        ent_t e;
        e.nm = nm;
        e.cp = cp;
        return e;
    endfunction

    function automatic logic [3:0] name_len(input logic [63:0] nm);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if (nm[8*i +: 8] != 8'd0) n = 4'(i + 1);
        end
        return n;
    endfunction

    function automatic digit_t digit_of(input logic [7:0] c, input logic hex);
        digit_t r;
        r.ok = 1'b0;
        r.d  = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.ok = 1'b1;
            r.d  = 4'(c - 8'h30);
        end else if (hex && c >= 8'h61 && c <= 8'h66) begin
            r.ok = 1'b1;
            r.d  = 4'(c - 8'h57);
        end else if (hex && c >= 8'h41 && c <= 8'h46) begin
            r.ok = 1'b1;
            r.d  = 4'(c - 8'h37);
        end
        return r;
    endfunction

    // number of UTF-8 bytes minus one
    function automatic logic [1:0] utf8_last(input logic [20:0] cp);
        logic [1:0] n;
        if (cp <= 21'h7F)        n = 2'd0;
        else if (cp <= 21'h7FF)  n = 2'd1;
        else if (cp <= 21'hFFFF) n = 2'd2;
        else                     n = 2'd3;
        return n;
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] i);
        logic [7:0] b;
        logic [1:0] n;
        n = utf8_last(cp);
        b = 8'h80 | {2'b00, cp[5:0]};
        case (n)
            2'd0: b = cp[7:0];
            2'd1: begin
                if (i == 2'd0) b = 8'hC0 | {3'b000, cp[10:6]};
            end
            2'd2: begin
                if (i == 2'd0)      b = 8'hE0 | {4'b0000, cp[15:12]};
                else if (i == 2'd1) b = 8'h80 | {2'b00, cp[11:6]};
            end
            default: begin
                if (i == 2'd0)      b = 8'hF0 | {5'b00000, cp[20:18]};
                else if (i == 2'd1) b = 8'h80 | {2'b00, cp[17:12]};
                else if (i == 2'd2) b = 8'h80 | {2'b00, cp[11:6]};
            end
        endcase
        return b;
    endfunction

    function automatic ent_t name_tbl(input logic [7:0] idx);
        ent_t e;
        case (idx)
            8'd0: e = ent("quot", 16'h0022);    8'd1: e = ent("frasl", 16'h2044);
            8'd2: e = ent("amp", 16'h0026);     8'd3: e = ent("lt", 16'h003C);
            8'd4: e = ent("gt", 16'h003E);      8'd5: e = ent("Agrave", 16'h00C0);
            8'd6: e = ent("Aacute", 16'h00C1);  8'd7: e = ent("Acirc", 16'h00C2);
            8'd8: e = ent("Atilde", 16'h00C3);  8'd9: e = ent("Auml", 16'h00C4);
            8'd10: e = ent("Aring", 16'h00C5);  8'd11: e = ent("AElig", 16'h00C6);
            8'd12: e = ent("Ccedil", 16'h00C7); 8'd13: e = ent("Egrave", 16'h00C8);
            8'd14: e = ent("Eacute", 16'h00C9); 8'd15: e = ent("Ecirc", 16'h00CA);
            8'd16: e = ent("Euml", 16'h00CB);   8'd17: e = ent("Igrave", 16'h00CC);
            8'd18: e = ent("Iacute", 16'h00CD); 8'd19: e = ent("Icirc", 16'h00CE);
            8'd20: e = ent("Iuml", 16'h00CF);   8'd21: e = ent("ETH", 16'h00D0);
            8'd22: e = ent("Ntilde", 16'h00D1); 8'd23: e = ent("Ograve", 16'h00D2);
            8'd24: e = ent("Oacute", 16'h00D3); 8'd25: e = ent("Ocirc", 16'h00D4);
            8'd26: e = ent("Otilde", 16'h00D5); 8'd27: e = ent("Ouml", 16'h00D6);
            8'd28: e = ent("Oslash", 16'h00D8); 8'd29: e = ent("Ugrave", 16'h00D9);
            8'd30: e = ent("Uacute", 16'h00DA); 8'd31: e = ent("Ucirc", 16'h00DB);
            8'd32: e = ent("Uuml", 16'h00DC);   8'd33: e = ent("Yacute", 16'h00DD);
            8'd34: e = ent("THORN", 16'h00DE);  8'd35: e = ent("szlig", 16'h00DF);
            8'd36: e = ent("agrave", 16'h00E0); 8'd37: e = ent("aacute", 16'h00E1);
            8'd38: e = ent("acirc", 16'h00E2);  8'd39: e = ent("atilde", 16'h00E3);
            8'd40: e = ent("auml", 16'h00E4);   8'd41: e = ent("aring", 16'h00E5);
            8'd42: e = ent("aelig", 16'h00E6);  8'd43: e = ent("ccedil", 16'h00E7);
            8'd44: e = ent("egrave", 16'h00E8); 8'd45: e = ent("eacute", 16'h00E9);
            8'd46: e = ent("ecirc", 16'h00EA);  8'd47: e = ent("euml", 16'h00EB);
            8'd48: e = ent("igrave", 16'h00EC); 8'd49: e = ent("iacute", 16'h00ED);
            8'd50: e = ent("icirc", 16'h00EE);  8'd51: e = ent("iuml", 16'h00EF);
            8'd52: e = ent("eth", 16'h00F0);    8'd53: e = ent("ntilde", 16'h00F1);
            8'd54: e = ent("ograve", 16'h00F2); 8'd55: e = ent("oacute", 16'h00F3);
            8'd56: e = ent("ocirc", 16'h00F4);  8'd57: e = ent("otilde", 16'h00F5);
            8'd58: e = ent("ouml", 16'h00F6);   8'd59: e = ent("oslash", 16'h00F8);
            8'd60: e = ent("ugrave", 16'h00F9); 8'd61: e = ent("uacute", 16'h00FA);
            8'd62: e = ent("ucirc", 16'h00FB);  8'd63: e = ent("uuml", 16'h00FC);
            8'd64: e = ent("yacute", 16'h00FD); 8'd65: e = ent("thorn", 16'h00FE);
            8'd66: e = ent("yuml", 16'h00FF);   8'd67: e = ent("nbsp", 16'h00A0);
            8'd68: e = ent("iexcl", 16'h00A1);  8'd69: e = ent("cent", 16'h00A2);
            8'd70: e = ent("pound", 16'h00A3);  8'd71: e = ent("curren", 16'h00A4);
            8'd72: e = ent("yen", 16'h00A5);    8'd73: e = ent("brvbar", 16'h00A6);
            8'd74: e = ent("sect", 16'h00A7);   8'd75: e = ent("uml", 16'h00A8);
            8'd76: e = ent("copy", 16'h00A9);   8'd77: e = ent("ordf", 16'h00AA);
            8'd78: e = ent("laquo", 16'h00AB);  8'd79: e = ent("not", 16'h00AC);
            8'd80: e = ent("shy", 16'h00AD);    8'd81: e = ent("reg", 16'h00AE);
            8'd82: e = ent("macr", 16'h00AF);   8'd83: e = ent("deg", 16'h00B0);
            8'd84: e = ent("plusmn", 16'h00B1); 8'd85: e = ent("sup2", 16'h00B2);
            8'd86: e = ent("sup3", 16'h00B3);   8'd87: e = ent("acute", 16'h00B4);
            8'd88: e = ent("micro", 16'h00B5);  8'd89: e = ent("para", 16'h00B6);
            8'd90: e = ent("cedil", 16'h00B8);  8'd91: e = ent("sup1", 16'h00B9);
            8'd92: e = ent("ordm", 16'h00BA);   8'd93: e = ent("raquo", 16'h00BB);
            8'd94: e = ent("frac14", 16'h00BC); 8'd95: e = ent("frac12", 16'h00BD);
            8'd96: e = ent("frac34", 16'h00BE); 8'd97: e = ent("iquest", 16'h00BF);
            8'd98: e = ent("times", 16'h00D7);  8'd99: e = ent("divide", 16'h00F7);
            8'd100: e = ent("forall", 16'h2200); 8'd101: e = ent("part", 16'h2202);
            8'd102: e = ent("exist", 16'h2203);  8'd103: e = ent("empty", 16'h2205);
            8'd104: e = ent("nabla", 16'h2207);  8'd105: e = ent("isin", 16'h2208);
            8'd106: e = ent("notin", 16'h2209);  8'd107: e = ent("ni", 16'h220B);
            8'd108: e = ent("prod", 16'h220F);   8'd109: e = ent("sum", 16'h2211);
            8'd110: e = ent("minus", 16'h2212);  8'd111: e = ent("lowast", 16'h2217);
            8'd112: e = ent("radic", 16'h221A);  8'd113: e = ent("prop", 16'h221D);
            8'd114: e = ent("infin", 16'h221E);  8'd115: e = ent("ang", 16'h2220);
            8'd116: e = ent("and", 16'h2227);    8'd117: e = ent("or", 16'h2228);
            8'd118: e = ent("cap", 16'h2229);    8'd119: e = ent("cup", 16'h222A);
            8'd120: e = ent("int", 16'h222B);    8'd121: e = ent("there4", 16'h2234);
            8'd122: e = ent("sim", 16'h223C);    8'd123: e = ent("cong", 16'h2245);
            8'd124: e = ent("asymp", 16'h2248);  8'd125: e = ent("ne", 16'h2260);
            8'd126: e = ent("equiv", 16'h2261);  8'd127: e = ent("le", 16'h2264);
            8'd128: e = ent("ge", 16'h2265);     8'd129: e = ent("sub", 16'h2282);
            8'd130: e = ent("sup", 16'h2283);    8'd131: e = ent("nsub", 16'h2284);
            8'd132: e = ent("sube", 16'h2286);   8'd133: e = ent("supe", 16'h2287);
            8'd134: e = ent("oplus", 16'h2295);  8'd135: e = ent("otimes", 16'h2297);
            8'd136: e = ent("perp", 16'h22A5);   8'd137: e = ent("sdot", 16'h22C5);
            8'd138: e = ent("Alpha", 16'h0391);  8'd139: e = ent("Beta", 16'h0392);
            8'd140: e = ent("Gamma", 16'h0393);  8'd141: e = ent("Delta", 16'h0394);
            8'd142: e = ent("Epsilon", 16'h0395); 8'd143: e = ent("Zeta", 16'h0396);
            8'd144: e = ent("Eta", 16'h0397);    8'd145: e = ent("Theta", 16'h0398);
            8'd146: e = ent("Iota", 16'h0399);   8'd147: e = ent("Kappa", 16'h039A);
            8'd148: e = ent("Lambda", 16'h039B); 8'd149: e = ent("Mu", 16'h039C);
            8'd150: e = ent("Nu", 16'h039D);     8'd151: e = ent("Xi", 16'h039E);
            8'd152: e = ent("Omicron", 16'h039F); 8'd153: e = ent("Pi", 16'h03A0);
            8'd154: e = ent("Rho", 16'h03A1);    8'd155: e = ent("Sigma", 16'h03A3);
            8'd156: e = ent("Tau", 16'h03A4);    8'd157: e = ent("Upsilon", 16'h03A5);
            8'd158: e = ent("Phi", 16'h03A6);    8'd159: e = ent("Chi", 16'h03A7);
            8'd160: e = ent("Psi", 16'h03A8);    8'd161: e = ent("Omega", 16'h03A9);
            8'd162: e = ent("alpha", 16'h03B1);  8'd163: e = ent("beta", 16'h03B2);
            8'd164: e = ent("gamma", 16'h03B3);  8'd165: e = ent("delta", 16'h03B4);
            8'd166: e = ent("epsilon", 16'h03B5); 8'd167: e = ent("zeta", 16'h03B6);
            8'd168: e = ent("eta", 16'h03B7);    8'd169: e = ent("theta", 16'h03B8);
            8'd170: e = ent("iota", 16'h03B9);   8'd171: e = ent("kappa", 16'h03BA);
            8'd172: e = ent("lambda", 16'h03BB); 8'd173: e = ent("mu", 16'h03BC);
            8'd174: e = ent("nu", 16'h03BD);     8'd175: e = ent("xi", 16'h03BE);
            8'd176: e = ent("omicron", 16'h03BF); 8'd177: e = ent("pi", 16'h03C0);
            8'd178: e = ent("rho", 16'h03C1);    8'd179: e = ent("sigmaf", 16'h03C2);
            8'd180: e = ent("sigma", 16'h03C3);  8'd181: e = ent("tau", 16'h03C4);
            8'd182: e = ent("upsilon", 16'h03C5); 8'd183: e = ent("phi", 16'h03C6);
            8'd184: e = ent("chi", 16'h03C7);    8'd185: e = ent("psi", 16'h03C8);
            8'd186: e = ent("omega", 16'h03C9);  8'd187: e = ent("thetasym", 16'h03D1);
            8'd188: e = ent("upsih", 16'h03D2);  8'd189: e = ent("piv", 16'h03D6);
            8'd190: e = ent("OElig", 16'h0152);  8'd191: e = ent("oelig", 16'h0153);
            8'd192: e = ent("Scaron", 16'h0160); 8'd193: e = ent("scaron", 16'h0161);
            8'd194: e = ent("Yuml", 16'h0178);   8'd195: e = ent("fnof", 16'h0192);
            8'd196: e = ent("circ", 16'h02C6);   8'd197: e = ent("tilde", 16'h02DC);
            8'd198: e = ent("ensp", 16'h2002);   8'd199: e = ent("emsp", 16'h2003);
            8'd200: e = ent("thinsp", 16'h2009); 8'd201: e = ent("zwnj", 16'h200C);
            8'd202: e = ent("zwj", 16'h200D);    8'd203: e = ent("lrm", 16'h200E);
            8'd204: e = ent("rlm", 16'h200F);    8'd205: e = ent("ndash", 16'h2013);
            8'd206: e = ent("mdash", 16'h2014);  8'd207: e = ent("lsquo", 16'h2018);
            8'd208: e = ent("rsquo", 16'h2019);  8'd209: e = ent("sbquo", 16'h201A);
            8'd210: e = ent("ldquo", 16'h201C);  8'd211: e = ent("rdquo", 16'h201D);
            8'd212: e = ent("bdquo", 16'h201E);  8'd213: e = ent("dagger", 16'h2020);
            8'd214: e = ent("Dagger", 16'h2021); 8'd215: e = ent("bull", 16'h2022);
            8'd216: e = ent("hellip", 16'h2026); 8'd217: e = ent("permil", 16'h2030);
            8'd218: e = ent("prime", 16'h2032);  8'd219: e = ent("Prime", 16'h2033);
            8'd220: e = ent("lsaquo", 16'h2039); 8'd221: e = ent("rsaquo", 16'h203A);
            8'd222: e = ent("oline", 16'h203E);  8'd223: e = ent("euro", 16'h20AC);
            8'd224: e = ent("trade", 16'h2122);  8'd225: e = ent("larr", 16'h2190);
            8'd226: e = ent("uarr", 16'h2191);   8'd227: e = ent("rarr", 16'h2192);
            8'd228: e = ent("darr", 16'h2193);   8'd229: e = ent("harr", 16'h2194);
            8'd230: e = ent("crarr", 16'h21B5);  8'd231: e = ent("lceil", 16'h2308);
            8'd232: e = ent("rceil", 16'h2309);  8'd233: e = ent("lfloor", 16'h230A);
            8'd234: e = ent("rfloor", 16'h230B); 8'd235: e = ent("loz", 16'h25CA);
            8'd236: e = ent("spades", 16'h2660); 8'd237: e = ent("clubs", 16'h2663);
            8'd238: e = ent("hearts", 16'h2665); 8'd239: e = ent("diams", 16'h2666);
            default: e = ent(64'd0, 16'd0);
        endcase
        return e;
    endfunction

endpackage

/* rtl/core/hed_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module hed_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/core/html_entity_decoder.sv */
// Top level of the HTML character reference decoder.
//
//  channel | dir | tdata          | tlast        | tuser
//  --------+-----+----------------+--------------+-----------
//  s_      | in  | text_byte[7:0] | end_of_text  | -
//  m_      | out | out_byte[7:0]  | run_last     | text_last
//
// Steps of a plain byte: accept, read wait, parse, end check, hand-off.
// A ';' that closes a named reference walks the name table, one entry a cycle;
// a failed reference emits '&' and replays its held bytes through the parser.
// An end-of-text flush reads out each held byte. s_tready is high only in idle.
// Reset (aresetn low, synchronous) empties the hold; the byte RAM needs no clearing.
// A stalled m_ side holds the sequencer at its next emitted beat.
module html_entity_decoder #(
    parameter int MAX_ENTITY_LEN = hed_pkg::MAX_ENTITY_LEN_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] text_byte
    input  logic       s_tlast,    // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_byte
    output logic       m_tlast,    // run_last
    output logic [0:0] m_tuser     // [0] text_last
);
    import hed_pkg::*;

    // queue depth: one spare slot so a full hold never aliases the write pointer
    localparam int DEPTH = 1 << $clog2(MAX_ENTITY_LEN + 1);
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = $clog2(MAX_ENTITY_LEN + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_WAIT  = 4'd1;  // RAM read in flight
    localparam logic [3:0] S_PROC  = 4'd2;  // parse one byte
    localparam logic [3:0] S_LOOK  = 4'd3;  // name table walk
    localparam logic [3:0] S_UTF   = 4'd4;  // emit UTF-8 bytes
    localparam logic [3:0] S_FAIL  = 4'd5;  // emit '&', replay
    localparam logic [3:0] S_DONE  = 4'd6;
    localparam logic [3:0] S_FWAIT = 4'd7;  // end-of-text flush read
    localparam logic [3:0] S_FEMIT = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;  // close the run

    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] end_reg, end_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] hs_reg, hs_next;
    logic          holding_reg, holding_next;
    logic [LW-1:0] len_reg, len_next;
    logic [2:0]    kind_reg, kind_next;
    logic [20:0]   val_reg, val_next;
    logic          ndig_reg, ndig_next;
    logic          bad_reg, bad_next;
    logic [63:0]   name_reg, name_next;
    logic [3:0]    nlen_reg, nlen_next;
    logic [7:0]    tidx_reg, tidx_next;
    logic [20:0]   cp_reg, cp_next;
    logic [1:0]    ui_reg, ui_next;
    logic          last_reg, last_next;
    logic          pend_v_reg;
    logic [7:0]    pend_reg;
    logic          m_tvalid_reg;
    logic [7:0]    m_tdata_reg;
    logic          m_tlast_reg;
    logic          m_tuser_reg;

    logic          ram_we;
    logic [7:0]    rdata;
    logic          out_free, can_emit;
    logic          emit_fire, fin_push;
    logic [7:0]    emit_byte;
    logic [7:0]    c;
    digit_t        dg;
    logic [24:0]   scaled, dsum;
    ent_t          te;
    logic [AW-1:0] pos_inc;

    hed_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (end_reg),
        .wdata (s_tdata),
        .raddr (pos_reg),
        .rdata (rdata)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign ram_we    = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tlast   = m_tlast_reg;
    assign m_tuser   = m_tuser_reg;

    // pending beat may move to the output register only when that is free
    assign out_free  = !m_tvalid_reg || m_tready;
    assign can_emit  = !pend_v_reg || out_free;

    assign c       = rdata;
    assign pos_inc = pos_reg + 1'b1;
    assign te      = name_tbl(tidx_reg);

    // shared digit unit: value * base + digit
    always_comb begin
        dg     = digit_of(c, kind_reg == K_HEX);
        scaled = (kind_reg == K_HEX) ? {val_reg, 4'b0000}
                                     : ({1'b0, val_reg, 3'b000} + {3'b000, val_reg, 1'b0});
        dsum   = scaled + {21'd0, dg.d};
    end

    always_comb begin
        state_next   = state_reg;
        end_next     = end_reg;
        pos_next     = pos_reg;
        hs_next      = hs_reg;
        holding_next = holding_reg;
        len_next     = len_reg;
        kind_next    = kind_reg;
        val_next     = val_reg;
        ndig_next    = ndig_reg;
        bad_next     = bad_reg;
        name_next    = name_reg;
        nlen_next    = nlen_reg;
        tidx_next    = tidx_reg;
        cp_next      = cp_reg;
        ui_next      = ui_reg;
        last_next    = last_reg;
        emit_fire    = 1'b0;
        emit_byte    = c;
        fin_push     = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    pos_next   = end_reg;
                    end_next   = end_reg + 1'b1;
                    last_next  = s_tlast;
                    state_next = S_WAIT;
                end
            end
            S_WAIT: state_next = S_PROC;
            S_PROC: begin
                if (!holding_reg) begin
                    if (c == CH_AMP) begin
                        holding_next = 1'b1;
                        hs_next      = pos_reg;
                        len_next     = LW'(1);
                        kind_next    = K_AMP;
                        val_next     = 21'd0;
                        ndig_next    = 1'b0;
                        bad_next     = 1'b0;
                        name_next    = 64'd0;
                        nlen_next    = 4'd0;
                        pos_next     = pos_inc;
                        state_next   = (pos_inc == end_reg) ? S_DONE : S_WAIT;
                    end else if (can_emit) begin
                        emit_fire  = 1'b1;
                        pos_next   = pos_inc;
                        state_next = (pos_inc == end_reg) ? S_DONE : S_WAIT;
                    end
                end else if (c == CH_SEMI) begin
                    case (kind_reg)
                        K_DEC, K_HEX: begin
                            if (ndig_reg && !bad_reg && val_reg != 21'd0) begin
                                cp_next    = val_reg;
                                ui_next    = 2'd0;
                                state_next = S_UTF;
                            end else begin
                                state_next = S_FAIL;
                            end
                        end
                        K_NAME: begin
                            tidx_next  = 8'd0;
                            state_next = (nlen_reg <= 4'd8) ? S_LOOK : S_FAIL;
                        end
                        default: state_next = S_FAIL;
                    endcase
                end else if ((LW + 1)'(len_reg) + 1'b1 < (LW + 1)'(MAX_ENTITY_LEN)) begin
                    len_next   = len_reg + 1'b1;
                    pos_next   = pos_inc;
                    state_next = (pos_inc == end_reg) ? S_DONE : S_WAIT;
                    case (kind_reg)
                        K_AMP: begin
                            if (c == CH_HASH) begin
                                kind_next = K_HASH;
                            end else begin
                                kind_next = K_NAME;
                                name_next = {name_reg[55:0], c};
                                nlen_next = 4'd1;
                            end
                        end
                        K_NAME: begin
                            name_next = {name_reg[55:0], c};
                            nlen_next = (nlen_reg == 4'd9) ? 4'd9 : nlen_reg + 1'b1;
                        end
                        default: begin
                            if (kind_reg == K_HASH && (c == CH_X_LO || c == CH_X_UP)) begin
                                kind_next = K_HEX;
                            end else begin
                                if (kind_reg == K_HASH) kind_next = K_DEC;
                                ndig_next = 1'b1;
                                if (!dg.ok) begin
                                    bad_next = 1'b1;
                                end else if (!bad_reg) begin
                                    val_next = dsum[20:0];
                                    if (dsum > {4'd0, CP_MAX}) bad_next = 1'b1;
                                end
                            end
                        end
                    endcase
                end else begin
                    // hold full without ';'
                    state_next = S_FAIL;
                end
            end
            S_LOOK: begin
                if (te.nm == name_reg && name_len(te.nm) == nlen_reg) begin
                    cp_next    = {5'd0, te.cp};
                    ui_next    = 2'd0;
                    state_next = S_UTF;
                end else if (tidx_reg == 8'(NAME_COUNT - 1)) begin
                    state_next = S_FAIL;
                end else begin
                    tidx_next = tidx_reg + 1'b1;
                end
            end
            S_UTF: begin
                if (can_emit) begin
                    emit_fire = 1'b1;
                    emit_byte = utf8_byte(cp_reg, ui_reg);
                    if (ui_reg == utf8_last(cp_reg)) begin
                        holding_next = 1'b0;
                        pos_next     = pos_inc;
                        state_next   = (pos_inc == end_reg) ? S_DONE : S_WAIT;
                    end else begin
                        ui_next = ui_reg + 1'b1;
                    end
                end
            end
            S_FAIL: begin
                if (can_emit) begin
                    emit_fire    = 1'b1;
                    emit_byte    = CH_AMP;
                    holding_next = 1'b0;
                    pos_next     = hs_reg + 1'b1;
                    state_next   = S_WAIT;
                end
            end
            S_DONE: begin
                if (last_reg && holding_reg) begin
                    pos_next   = hs_reg;
                    state_next = S_FWAIT;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_FWAIT: state_next = S_FEMIT;
            S_FEMIT: begin
                if (can_emit) begin
                    emit_fire = 1'b1;
                    if (pos_inc == end_reg) begin
                        holding_next = 1'b0;
                        state_next   = S_FIN;
                    end else begin
                        pos_next   = pos_inc;
                        state_next = S_FWAIT;
                    end
                end
            end
            S_FIN: begin
                if (!pend_v_reg) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    fin_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            end_reg      <= '0;
            pos_reg      <= '0;
            hs_reg       <= '0;
            holding_reg  <= 1'b0;
            pend_v_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            end_reg     <= end_next;
            pos_reg     <= pos_next;
            hs_reg      <= hs_next;
            holding_reg <= holding_next;

            // one beat held back so the run's final beat can carry tlast
            if (emit_fire) begin
                pend_v_reg <= 1'b1;
            end else if (fin_push) begin
                pend_v_reg <= 1'b0;
            end

            if ((emit_fire && pend_v_reg) || fin_push) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        len_reg  <= len_next;
        kind_reg <= kind_next;
        val_reg  <= val_next;
        ndig_reg <= ndig_next;
        bad_reg  <= bad_next;
        name_reg <= name_next;
        nlen_reg <= nlen_next;
        tidx_reg <= tidx_next;
        cp_reg   <= cp_next;
        ui_reg   <= ui_next;
        last_reg <= last_next;
        if (emit_fire) begin
            pend_reg <= emit_byte;
        end
        if (emit_fire && pend_v_reg) begin
            m_tdata_reg <= pend_reg;
            m_tlast_reg <= 1'b0;
            m_tuser_reg <= 1'b0;
        end else if (fin_push) begin
            m_tdata_reg <= pend_reg;
            m_tlast_reg <= 1'b1;
            m_tuser_reg <= last_reg;
        end
    end
endmodule

/* rtl/core/hed_checker.sv */
// Port-level checker of the entity decoder, bound to the top level.
`include "html_entity_decoder_defines.svh"
module hed_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [0:0] m_tuser
);
    // a stalled beat stays valid and keeps its tdata and tlast
    `HED_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    // end of text is always the end of a run
    `HED_ASSERT_IMP(a_text_end_is_run_end, aclk, aresetn, m_tvalid && m_tuser[0], m_tlast)
    // an accepted byte closes the input while its read is in flight
    `HED_ASSERT_NXT(a_busy_after_beat, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // an input beat yields no output beat before its parse has run
    `HED_ASSERT_NXT(a_no_instant_out, aclk, aresetn, s_tvalid && s_tready && (!m_tvalid || m_tready), !m_tvalid)
endmodule

bind html_entity_decoder hed_checker u_hed_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

/* sim/hed_checker.sv */
// Checker for the entity decoder: predicts the output beats and compares them.
module hed_scoreboard (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic       m_tlast,
    input  logic [0:0] m_tuser,
    output int         fail_count,
    output int         beats_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import hed_pkg::*;

    localparam int HOLD_MAX = MAX_ENTITY_LEN_DEF;

    typedef struct {
        logic [7:0] out_byte;
        logic       run_last;
        logic       text_last;
    } dec_beat_t;

    dec_beat_t   due_beats[$];
    logic [7:0]  held_q[$];
    int          ref_points[string];

    // name:codepoint pairs of the entity table
    localparam string ENT_LIST = {
        "quot:22 frasl:2044 amp:26 lt:3C gt:3E Agrave:C0 Aacute:C1 Acirc:C2 Atilde:C3 ",
        "Auml:C4 Aring:C5 AElig:C6 Ccedil:C7 Egrave:C8 Eacute:C9 Ecirc:CA Euml:CB ",
        "Igrave:CC Iacute:CD Icirc:CE Iuml:CF ETH:D0 Ntilde:D1 Ograve:D2 Oacute:D3 ",
        "Ocirc:D4 Otilde:D5 Ouml:D6 Oslash:D8 Ugrave:D9 Uacute:DA Ucirc:DB Uuml:DC ",
        "Yacute:DD THORN:DE szlig:DF agrave:E0 aacute:E1 acirc:E2 atilde:E3 auml:E4 ",
        "aring:E5 aelig:E6 ccedil:E7 egrave:E8 eacute:E9 ecirc:EA euml:EB igrave:EC ",
        "iacute:ED icirc:EE iuml:EF eth:F0 ntilde:F1 ograve:F2 oacute:F3 ocirc:F4 ",
        "otilde:F5 ouml:F6 oslash:F8 ugrave:F9 uacute:FA ucirc:FB uuml:FC yacute:FD ",
        "thorn:FE yuml:FF nbsp:A0 iexcl:A1 cent:A2 pound:A3 curren:A4 yen:A5 brvbar:A6 ",
        "sect:A7 uml:A8 copy:A9 ordf:AA laquo:AB not:AC shy:AD reg:AE macr:AF deg:B0 ",
        "plusmn:B1 sup2:B2 sup3:B3 acute:B4 micro:B5 para:B6 cedil:B8 sup1:B9 ordm:BA ",
        "raquo:BB frac14:BC frac12:BD frac34:BE iquest:BF times:D7 divide:F7 ",
        "forall:2200 part:2202 exist:2203 empty:2205 nabla:2207 isin:2208 notin:2209 ",
        "ni:220B prod:220F sum:2211 minus:2212 lowast:2217 radic:221A prop:221D ",
        "infin:221E ang:2220 and:2227 or:2228 cap:2229 cup:222A int:222B there4:2234 ",
        "sim:223C cong:2245 asymp:2248 ne:2260 equiv:2261 le:2264 ge:2265 sub:2282 ",
        "sup:2283 nsub:2284 sube:2286 supe:2287 oplus:2295 otimes:2297 perp:22A5 ",
        "sdot:22C5 Alpha:391 Beta:392 Gamma:393 Delta:394 Epsilon:395 Zeta:396 ",
        "Eta:397 Theta:398 Iota:399 Kappa:39A Lambda:39B Mu:39C Nu:39D Xi:39E ",
        "Omicron:39F Pi:3A0 Rho:3A1 Sigma:3A3 Tau:3A4 Upsilon:3A5 Phi:3A6 Chi:3A7 ",
        "Psi:3A8 Omega:3A9 alpha:3B1 beta:3B2 gamma:3B3 delta:3B4 epsilon:3B5 ",
        "zeta:3B6 eta:3B7 theta:3B8 iota:3B9 kappa:3BA lambda:3BB mu:3BC nu:3BD ",
        "xi:3BE omicron:3BF pi:3C0 rho:3C1 sigmaf:3C2 sigma:3C3 tau:3C4 upsilon:3C5 ",
        "phi:3C6 chi:3C7 psi:3C8 omega:3C9 thetasym:3D1 upsih:3D2 piv:3D6 OElig:152 ",
        "oelig:153 Scaron:160 scaron:161 Yuml:178 fnof:192 circ:2C6 tilde:2DC ",
        "ensp:2002 emsp:2003 thinsp:2009 zwnj:200C zwj:200D lrm:200E rlm:200F ",
        "ndash:2013 mdash:2014 lsquo:2018 rsquo:2019 sbquo:201A ldquo:201C ",
        "rdquo:201D bdquo:201E dagger:2020 Dagger:2021 bull:2022 hellip:2026 ",
        "permil:2030 prime:2032 Prime:2033 lsaquo:2039 rsaquo:203A oline:203E ",
        "euro:20AC trade:2122 larr:2190 uarr:2191 rarr:2192 darr:2193 harr:2194 ",
        "crarr:21B5 lceil:2308 rceil:2309 lfloor:230A rfloor:230B loz:25CA ",
        "spades:2660 clubs:2663 hearts:2665 diams:2666 "
    };

    initial begin
        string nm;
        string hx;
        int    v;
        bit    in_hex;
        nm = "";
        hx = "";
        in_hex = 1'b0;
        for (int i = 0; i < ENT_LIST.len(); i++) begin
            if (ENT_LIST[i] == ":") begin
                in_hex = 1'b1;
            end else if (ENT_LIST[i] == " ") begin
                v = hx.atohex();
                ref_points[nm] = v;
                nm = "";
                hx = "";
                in_hex = 1'b0;
            end else if (in_hex) begin
                hx = {hx, ENT_LIST[i]};
            end else begin
                nm = {nm, ENT_LIST[i]};
            end
        end
    end

    function automatic int hex_digit(logic [7:0] c, bit hex);
        if (c >= "0" && c <= "9") return c - "0";
        if (hex && c >= "a" && c <= "f") return c - "a" + 10;
        if (hex && c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    // r[hs] is '&', r[hs+len-1] is ';'
    function automatic bit lookup_ref(ref logic [7:0] r[$], input int hs, input int len,
                                      output int cp);
        int    base, first, d, k;
        int    v;
        string nm;
        cp = 0;
        if (len < 3) return 1'b0;
        if (r[hs+1] == CH_HASH) begin
            base = 10;
            first = 2;
            if (r[hs+2] == CH_X_LO || r[hs+2] == CH_X_UP) begin
                base = 16;
                first = 3;
            end
            if (first > len - 2) return 1'b0;
            v = 0;
            for (int i = first; i <= len - 2; i++) begin
                d = hex_digit(r[hs+i], base == 16);
                if (d < 0) return 1'b0;
                v = v * base + d;
                if (v > int'(CP_MAX)) return 1'b0;
            end
            if (v == 0) return 1'b0;
            cp = v;
            return 1'b1;
        end
        k = len - 2;
        if (k > 8) return 1'b0;
        nm = "";
        for (int i = 1; i <= k; i++) begin
            if (r[hs+i] == 8'h00) return 1'b0;
            nm = {nm, string'(r[hs+i])};
        end
        if (!ref_points.exists(nm)) return 1'b0;
        cp = ref_points[nm];
        return 1'b1;
    endfunction

    function automatic void push_utf8(ref logic [7:0] o[$], input int cp);
        if (cp <= 'h7F) begin
            o.push_back(cp[7:0]);
        end else if (cp <= 'h7FF) begin
            o.push_back(8'hC0 | cp[10:6]);
            o.push_back(8'h80 | cp[5:0]);
        end else if (cp <= 'hFFFF) begin
            o.push_back(8'hE0 | cp[15:12]);
            o.push_back(8'h80 | cp[11:6]);
            o.push_back(8'h80 | cp[5:0]);
        end else begin
            o.push_back(8'hF0 | cp[20:18]);
            o.push_back(8'h80 | cp[17:12]);
            o.push_back(8'h80 | cp[11:6]);
            o.push_back(8'h80 | cp[5:0]);
        end
    endfunction

    // one accepted text byte: update the hold and queue the beats it causes
    function automatic void decode_byte(logic [7:0] c, logic eot);
        logic [7:0] q[$];
        logic [7:0] o[$];
        int         pos, hs, len, cp;
        bit         holding;
        dec_beat_t  b;
        q = held_q;
        q.push_back(c);
        holding = held_q.size() > 0;
        hs = 0;
        pos = held_q.size();
        while (pos < q.size()) begin
            if (!holding) begin
                if (q[pos] == CH_AMP) begin
                    holding = 1'b1;
                    hs = pos;
                end else begin
                    o.push_back(q[pos]);
                end
                pos++;
            end else begin
                len = pos - hs + 1;
                if (q[pos] == CH_SEMI && lookup_ref(q, hs, len, cp)) begin
                    push_utf8(o, cp);
                    holding = 1'b0;
                    pos++;
                end else if (q[pos] != CH_SEMI && len < HOLD_MAX) begin
                    pos++;
                end else begin
                    // failed: '&' goes out, the rest is parsed again
                    o.push_back(CH_AMP);
                    pos = hs + 1;
                    holding = 1'b0;
                end
            end
        end
        held_q.delete();
        if (holding) held_q = q[hs:$];
        if (eot) begin
            foreach (held_q[i]) o.push_back(held_q[i]);
            held_q.delete();
        end
        foreach (o[i]) begin
            b.out_byte  = o[i];
            b.run_last  = (i == o.size() - 1);
            b.text_last = eot && (i == o.size() - 1);
            due_beats.push_back(b);
        end
    endfunction

    always @(posedge aclk) begin
        dec_beat_t e;
        if (aresetn) begin
            if (s_tvalid && s_tready) decode_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                if (due_beats.size() == 0) begin
                    $error("unexpected beat out_byte=%h", m_tdata);
                    fail_count++;
                end else begin
                    e = due_beats.pop_front();
                    if (m_tdata !== e.out_byte) begin
                        $error("out_byte: expected %h, got %h", e.out_byte, m_tdata);
                        fail_count++;
                    end
                    if (m_tlast !== e.run_last) begin
                        $error("run_last: expected %b, got %b", e.run_last, m_tlast);
                        fail_count++;
                    end
                    if (m_tuser[0] !== e.text_last) begin
                        $error("text_last: expected %b, got %b", e.text_last, m_tuser[0]);
                        fail_count++;
                    end
                end
            end
        end
        beats_due <= due_beats.size();
    end

endmodule

/* sim/tb_html_entity_decoder.sv */
// Testbench top of the entity decoder: stimulus, flow control and verdict.
module tb_html_entity_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import hed_pkg::*;

    localparam int IDLE_LIMIT = 20000;   // cycles without any beat before giving up
    localparam int RAND_ITEMS = 60;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [0:0] m_tuser;

    int fail_count;
    int beats_due;
    int idle_cycles = 0;
    int burst_left = 0;

    // text bytes and their end-of-text marks, in sending order
    logic [7:0] text_q[$];
    logic       eot_q[$];

    string ref_names[10] = '{"amp", "lt", "thetasym", "Omicron", "euro",
                             "diams", "nbsp", "ni", "quot", "AElig"};

    always #5 aclk = ~aclk;

    html_entity_decoder uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser)
    );

    hed_scoreboard chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser), .fail_count(fail_count), .beats_due(beats_due)
    );

    // receiver: mode rotates between free flow, random and sparse
    always @(posedge aclk) begin
        int mode;
        mode = ($time / 640) % 3;
        case (mode)
            0: m_tready <= 1'b1;
            1: m_tready <= $urandom_range(0, 1);
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // watchdog on beats of either channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("** html_entity_decoder: FAILED **");
            $finish;
        end
    end

    task automatic add_text(string s, bit eot = 1'b0);
        for (int i = 0; i < s.len(); i++) begin
            text_q.push_back(s[i]);
            eot_q.push_back(eot && (i == s.len() - 1));
        end
    endtask

    // one beat on the input channel, bursts with random gaps in between
    task automatic send_byte(logic [7:0] b, logic eot);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eot;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic flush_text();
        while (text_q.size() > 0) send_byte(text_q.pop_front(), eot_q.pop_front());
    endtask

    // one random fragment of text; mostly well-formed references
    task automatic add_fragment();
        string s;
        int    v, pick;
        bit    eot;
        eot = ($urandom_range(0, 11) == 0);
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2: s = {"&", ref_names[$urandom_range(0, 9)], ";"};
            3, 4: begin
                v = $urandom_range(0, 3) == 0 ? $urandom_range(0, 300)
                                             : $urandom_range(0, 'h110010);
                s = $sformatf("&#%0d;", v);
            end
            5: begin
                v = $urandom_range(0, 'h110010);
                if ($urandom_range(0, 1)) begin
                    s = $sformatf("&#x%0h;", v);
                end else begin
                    s = $sformatf("&#X%0h;", v);
                    s = s.toupper();
                end
            end
            6: begin
                // broken reference: one byte replaced
                s = {"&", ref_names[$urandom_range(0, 9)], ";"};
                s[$urandom_range(1, s.len() - 1)] = $urandom_range(0, 255);
            end
            7: begin
                // over-long reference, no ';'
                s = "&";
                repeat ($urandom_range(20, 40)) s = {s, string'(8'($urandom_range(97, 122)))};
            end
            default: begin
                s = "";
                repeat ($urandom_range(1, 4)) begin
                    text_q.push_back($urandom_range(0, 255));
                    eot_q.push_back(1'b0);
                end
            end
        endcase
        add_text(s, eot);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: good names, numeric extremes, and the failure cases
        add_text("A&amp;&thetasym;&#65;&#x10FFFF;&#X1F600;&#0000065;&#xD800;");
        add_text("&;&#;&#x;&#12a;&#0;&#x110000;&a&lt;&AMP;");
        text_q.push_back(8'h00); eot_q.push_back(1'b0);
        text_q.push_back(8'hFF); eot_q.push_back(1'b0);
        add_text("&abcdefghijklmnopqrstuvwxyz0123456789;");
        add_text("x&gt", 1'b1);
        flush_text();

        // hold off until every beat so far is out
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (beats_due == 0 && !m_tvalid);
        @(posedge aclk);

        while (text_q.size() < RAND_ITEMS) add_fragment();
        add_text("&euro", 1'b1);
        flush_text();
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        @(posedge aclk);
        wait (beats_due == 0);
        repeat (600) @(posedge aclk);
        if (fail_count == 0 && beats_due == 0) begin
            $display("** html_entity_decoder: PASSED **");
        end else begin
            $display("** html_entity_decoder: FAILED **");
        end
        $finish;
    end

endmodule
